// ----- src/tgen_pkg.sv -----
// Shared types, register codes and fixed-point constants of the tone generator.
`default_nettype none

package tgen_pkg;

   // Default parameter values.
   localparam int TABLE_ADDR_BITS_DEF = 8;
   localparam int LENGTH_BITS_DEF     = 24;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_PHASE_STEP    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_VOLUME        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_NOTE_LENGTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ATTACK_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FADE_START    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_WAVE_SHAPE    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_ATTACK_STEP   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_FADE_STEP     = 3'd7;

   // Wave shape codes; the remaining codes give silence.
   localparam logic [2:0] SHAPE_RAISED_COS   = 3'd0;
   localparam logic [2:0] SHAPE_NOISY_SINE   = 3'd1;
   localparam logic [2:0] SHAPE_NOISY_SQUARE = 3'd2;
   localparam logic [2:0] SHAPE_SQUARE       = 3'd3;
   localparam logic [2:0] SHAPE_NOISE        = 3'd4;

   // Fixed-point constants, Q16 where 65536 is 1.0.
   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic [16:0] SIN_C1  = 17'd102944;
   localparam logic [16:0] SIN_C3  = 17'd42334;
   localparam logic [16:0] SIN_C5  = 17'd5223;
   localparam logic [16:0] SIN_C7  = 17'd307;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] LFSR_TAPS    = 32'hA300_0000;
   localparam logic [31:0] LFSR_SEED    = 32'h0000_ACE1;
   localparam logic [7:0]  SAMPLE_MAX   = 8'd255;

   // Shared multiplier geometry.
   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Configuration register contents.
   typedef struct packed {
      logic [31:0] phase_step;
      logic [7:0]  volume;
      logic [23:0] note_length;
      logic [23:0] attack_length;
      logic [23:0] fade_start;
      logic [2:0]  wave_shape;
      logic [16:0] attack_step;
      logic [16:0] fade_step;
   } cfg_type;

   // Sequencer states.
   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_EV    = 11'b000_0000_0010,
      S_WAVE  = 11'b000_0000_0100,
      S_T1    = 11'b000_0000_1000,
      S_T2    = 11'b000_0001_0000,
      S_T3    = 11'b000_0010_0000,
      S_T4    = 11'b000_0100_0000,
      S_RAISE = 11'b000_1000_0000,
      S_NOISE = 11'b001_0000_0000,
      S_FIN   = 11'b010_0000_0000,
      S_OUT   = 11'b100_0000_0000
   } state_type;

endpackage

`default_nettype wire

// ----- src/tgen_csr.sv -----
// Configuration register file of the tone generator.
`default_nettype none

module tgen_csr #(
   parameter int LENGTH_BITS = tgen_pkg::LENGTH_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [tgen_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tgen_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output tgen_pkg::cfg_type                      cfg
);

   // Length registers keep no more bits than the index counter has.
   localparam int LEN_KEEP = (LENGTH_BITS < 24) ? LENGTH_BITS : 24;
   localparam logic [23:0] LEN_MASK = 24'((64'(1) << LEN_KEEP) - 64'(1));

   tgen_pkg::cfg_type cfg_ff, cfg_in;

   // Decode one write into the register it addresses.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            tgen_pkg::REG_PHASE_STEP:    cfg_in.phase_step    = csr_wdata;
            tgen_pkg::REG_VOLUME:        cfg_in.volume        = csr_wdata[7:0];
            tgen_pkg::REG_NOTE_LENGTH:   cfg_in.note_length   = csr_wdata[23:0] & LEN_MASK;
            tgen_pkg::REG_ATTACK_LENGTH: cfg_in.attack_length = csr_wdata[23:0] & LEN_MASK;
            tgen_pkg::REG_FADE_START:    cfg_in.fade_start    = csr_wdata[23:0] & LEN_MASK;
            tgen_pkg::REG_WAVE_SHAPE:    cfg_in.wave_shape    = csr_wdata[2:0];
            tgen_pkg::REG_ATTACK_STEP:   cfg_in.attack_step   = csr_wdata[16:0];
            tgen_pkg::REG_FADE_STEP:     cfg_in.fade_step     = csr_wdata[16:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- src/tgen_mul.sv -----
// Shared multiplier with a registered product.
`default_nettype none

module tgen_mul (
   input  wire logic                            clock,
   input  wire logic                            mul_en,
   input  wire logic [tgen_pkg::MUL_A_W-1:0]    mul_a,
   input  wire logic [tgen_pkg::MUL_B_W-1:0]    mul_b,
   output logic      [tgen_pkg::MUL_P_W-1:0]    mul_prod
);

   logic [tgen_pkg::MUL_P_W-1:0] prod_ff;

   // The product holds while the sequencer does not need a new one.
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= tgen_pkg::MUL_P_W'(mul_a) * tgen_pkg::MUL_P_W'(mul_b);
      end
   end

   assign mul_prod = prod_ff;

endmodule

`default_nettype wire

// ----- src/tone_generator_with_envelope_core.sv -----
// Top level of the tone generator: sequencer, voice state and result register.
//
//   channel  direction  handshake                  payload
//   req      in         req_valid / req_stall      req_start_note
//   rsp      out        rsp_valid / rsp_stall      rsp_sample, rsp_last_of_note, rsp_playing
//   csr      in         csr_wr_en (no wait)        csr_index, csr_wdata
//
// A request with no active note goes straight to the output state. Other samples pass the
// envelope, wave and final product states through the one shared multiplier, a cosine or
// noisy sine also the Horner steps and the raise, a noisy sine the noise product. Reset is
// synchronous and clears the voice state, with the noise register loaded with its seed. A
// stalled result waits in the output register; the next request is taken once it is loaded.
`default_nettype none

module tone_generator_with_envelope_core #(
   parameter int TABLE_ADDR_BITS = tgen_pkg::TABLE_ADDR_BITS_DEF,
   parameter int LENGTH_BITS     = tgen_pkg::LENGTH_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_start_note,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [7:0]                        rsp_sample,
   output logic                                   rsp_last_of_note,
   output logic                                   rsp_playing,
   input  wire logic                              csr_wr_en,
   input  wire logic [tgen_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tgen_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW = tgen_pkg::MUL_A_W;
   localparam int BW = tgen_pkg::MUL_B_W;
   localparam int PW = tgen_pkg::MUL_P_W;
   localparam logic [31:0] PHASE_MASK =
      ~32'((64'(1) << (32 - TABLE_ADDR_BITS)) - 64'(1));

   tgen_pkg::cfg_type cfg;

   tgen_csr #(.LENGTH_BITS(LENGTH_BITS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   logic          mul_en;
   logic [AW-1:0] mul_a;
   logic [BW-1:0] mul_b;
   logic [PW-1:0] prod;

   tgen_mul u_mul (
      .clock    (clock),
      .mul_en   (mul_en),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (prod)
   );

   tgen_pkg::state_type state_ff, state_in;

   // Voice state.
   logic [31:0]            phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] index_ff, index_in;
   logic [16:0]            env_ff, env_in;
   logic [31:0]            lfsr_ff, lfsr_in;
   logic                   active_ff, active_in;

   // Working registers of one sample.
   logic [AW-1:0] ev_ff, ev_in;
   logic [16:0]   x_ff, x_in;
   logic [16:0]   x2_ff, x2_in;
   logic          neg_ff, neg_in;
   logic [15:0]   noise_ff, noise_in;
   logic [16:0]   wave_ff, wave_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_sample_ff, rsp_sample_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_playing_ff, rsp_playing_in;

   // Intermediate values.
   logic [31:0] phase_p, phase_s;
   logic        sine_pos;
   logic [16:0] x_cur;
   logic [31:0] lfsr_next;
   logic [16:0] mag;
   logic [17:0] raised_sum;
   logic [16:0] raised_diff;
   logic [16:0] raised;
   logic [17:0] env_sum;
   logic        last;
   logic        out_free;
   logic        req_take;
   logic        active_start;

   // Phase folding, noise step and sine magnitude.
   always_comb begin
      phase_p  = phase_ff & PHASE_MASK;
      phase_s  = (cfg.wave_shape == tgen_pkg::SHAPE_RAISED_COS) ?
                 phase_p + tgen_pkg::QUARTER_TURN : phase_p;
      x_cur    = phase_s[30] ? tgen_pkg::ONE_Q16 - {1'b0, phase_s[29:14]}
                             : {1'b0, phase_s[29:14]};
      sine_pos = ((phase_p[31:30] == 2'b00) && (phase_p[29:14] != 16'd0)) ||
                 (phase_p[31:30] == 2'b01);
      lfsr_next = lfsr_ff[0] ? ({1'b0, lfsr_ff[31:1]} ^ tgen_pkg::LFSR_TAPS)
                             : {1'b0, lfsr_ff[31:1]};
      mag = (prod[PW-1:16] > (PW-16)'(tgen_pkg::ONE_Q16)) ? tgen_pkg::ONE_Q16 : prod[32:16];
      raised_sum  = {1'b0, tgen_pkg::ONE_Q16} + {1'b0, mag};
      raised_diff = tgen_pkg::ONE_Q16 - mag;
      raised      = neg_ff ? {1'b0, raised_diff[16:1]} : raised_sum[17:1];
      env_sum     = {1'b0, env_ff} + {1'b0, cfg.attack_step};
      last        = 32'(index_ff) == (32'(cfg.note_length) - 32'd1);
   end

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign req_take     = (state_ff == tgen_pkg::S_IDLE) && req_valid;
   assign active_start = req_start_note ? (cfg.note_length != 24'd0) : active_ff;

   // Sequencer and multiplier operand selection.
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      index_in       = index_ff;
      env_in         = env_ff;
      lfsr_in        = lfsr_ff;
      active_in      = active_ff;
      ev_in          = ev_ff;
      x_in           = x_ff;
      x2_in          = x2_ff;
      neg_in         = neg_ff;
      noise_in       = noise_ff;
      wave_in        = wave_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_sample_in  = rsp_sample_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_playing_in = rsp_playing_ff;
      mul_en         = 1'b0;
      mul_a          = '0;
      mul_b          = '0;

      case (state_ff)
         tgen_pkg::S_IDLE: begin
            // A start clears the index and sets the envelope's first level.
            if (req_valid) begin
               if (req_start_note) begin
                  index_in = '0;
                  env_in   = (cfg.attack_length == 24'd0) ? tgen_pkg::ONE_Q16 : 17'd0;
               end
               active_in = active_start;
               state_in  = active_start ? tgen_pkg::S_EV : tgen_pkg::S_OUT;
            end
         end
         tgen_pkg::S_EV: begin
            // Envelope times volume.
            mul_en   = 1'b1;
            mul_a    = AW'(cfg.volume);
            mul_b    = env_ff;
            state_in = tgen_pkg::S_WAVE;
         end
         tgen_pkg::S_WAVE: begin
            // Keep the scaled envelope, start the sine with x squared, pick the shape.
            ev_in  = prod[AW-1:0];
            x_in   = x_cur;
            neg_in = phase_s[31];
            mul_en = 1'b1;
            mul_a  = AW'(x_cur);
            mul_b  = x_cur;
            if ((cfg.wave_shape == tgen_pkg::SHAPE_NOISY_SINE) ||
                (cfg.wave_shape == tgen_pkg::SHAPE_NOISY_SQUARE) ||
                (cfg.wave_shape == tgen_pkg::SHAPE_NOISE)) begin
               lfsr_in = lfsr_next;
            end
            noise_in = lfsr_next[31:16];
            case (cfg.wave_shape)
               tgen_pkg::SHAPE_NOISY_SQUARE:
                  wave_in = sine_pos ? {1'b0, lfsr_next[31:16]} : 17'd0;
               tgen_pkg::SHAPE_SQUARE:
                  wave_in = sine_pos ? tgen_pkg::ONE_Q16 : 17'd0;
               tgen_pkg::SHAPE_NOISE:
                  wave_in = {1'b0, lfsr_next[31:16]};
               default:
                  wave_in = 17'd0;
            endcase
            if ((cfg.wave_shape == tgen_pkg::SHAPE_RAISED_COS) ||
                (cfg.wave_shape == tgen_pkg::SHAPE_NOISY_SINE)) begin
               state_in = tgen_pkg::S_T1;
            end else begin
               state_in = tgen_pkg::S_FIN;
            end
         end
         tgen_pkg::S_T1: begin
            // x2 times the highest coefficient.
            x2_in    = prod[32:16];
            mul_en   = 1'b1;
            mul_a    = AW'(tgen_pkg::SIN_C7);
            mul_b    = prod[32:16];
            state_in = tgen_pkg::S_T2;
         end
         tgen_pkg::S_T2: begin
            mul_en   = 1'b1;
            mul_a    = AW'(17'(tgen_pkg::SIN_C5 - prod[32:16]));
            mul_b    = x2_ff;
            state_in = tgen_pkg::S_T3;
         end
         tgen_pkg::S_T3: begin
            mul_en   = 1'b1;
            mul_a    = AW'(17'(tgen_pkg::SIN_C3 - prod[32:16]));
            mul_b    = x2_ff;
            state_in = tgen_pkg::S_T4;
         end
         tgen_pkg::S_T4: begin
            // Last Horner step multiplies by x itself.
            mul_en   = 1'b1;
            mul_a    = AW'(17'(tgen_pkg::SIN_C1 - prod[32:16]));
            mul_b    = x_ff;
            state_in = tgen_pkg::S_RAISE;
         end
         tgen_pkg::S_RAISE: begin
            // Raised sine, and for the noisy sine its product with the noise.
            wave_in = raised;
            if (cfg.wave_shape == tgen_pkg::SHAPE_NOISY_SINE) begin
               mul_en   = 1'b1;
               mul_a    = AW'(raised);
               mul_b    = {1'b0, noise_ff};
               state_in = tgen_pkg::S_NOISE;
            end else begin
               state_in = tgen_pkg::S_FIN;
            end
         end
         tgen_pkg::S_NOISE: begin
            wave_in  = prod[32:16];
            state_in = tgen_pkg::S_FIN;
         end
         tgen_pkg::S_FIN: begin
            mul_en   = 1'b1;
            mul_a    = ev_ff;
            mul_b    = wave_ff;
            state_in = tgen_pkg::S_OUT;
         end
         tgen_pkg::S_OUT: begin
            // Load the result and advance the voice once the output register is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = tgen_pkg::S_IDLE;
               if (active_ff) begin
                  rsp_sample_in  = (prod[PW-1:32] > (PW-32)'(tgen_pkg::SAMPLE_MAX)) ?
                                   tgen_pkg::SAMPLE_MAX : prod[39:32];
                  rsp_last_in    = last;
                  rsp_playing_in = 1'b1;
                  if (32'(index_ff) < 32'(cfg.attack_length)) begin
                     env_in = (env_sum > 18'(tgen_pkg::ONE_Q16)) ?
                              tgen_pkg::ONE_Q16 : env_sum[16:0];
                  end else if (32'(index_ff) > 32'(cfg.fade_start)) begin
                     env_in = (env_ff > cfg.fade_step) ? env_ff - cfg.fade_step : 17'd0;
                  end
                  phase_in = phase_ff + cfg.phase_step;
                  index_in = index_ff + LENGTH_BITS'(1);
                  if (last) begin
                     active_in = 1'b0;
                  end
               end else begin
                  rsp_sample_in  = 8'd0;
                  rsp_last_in    = 1'b0;
                  rsp_playing_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = tgen_pkg::S_IDLE;
         end
      endcase
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tgen_pkg::S_IDLE;
         phase_ff     <= '0;
         index_ff     <= '0;
         env_ff       <= '0;
         lfsr_ff      <= tgen_pkg::LFSR_SEED;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         index_ff     <= index_in;
         env_ff       <= env_in;
         lfsr_ff      <= lfsr_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ev_ff          <= ev_in;
      x_ff           <= x_in;
      x2_ff          <= x2_in;
      neg_ff         <= neg_in;
      noise_ff       <= noise_in;
      wave_ff        <= wave_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_playing_ff <= rsp_playing_in;
   end

   assign req_stall        = state_ff != tgen_pkg::S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample       = rsp_sample_ff;
   assign rsp_last_of_note = rsp_last_ff;
   assign rsp_playing      = rsp_playing_ff;

   // The envelope never goes above full level.
   a_env_bound: assert property (@(posedge clock) disable iff (reset)
      env_ff <= tgen_pkg::ONE_Q16)
      else $error("envelope above full level");

   // The noise register never locks up at zero.
   a_lfsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != 32'd0)
      else $error("noise register reached zero");

   // A silent result carries no sample and no end of note.
   a_silent_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_playing_ff) |-> (rsp_sample_ff == 8'd0) && !rsp_last_ff)
      else $error("silent result carries data");

   // Each played sample advances the index by one.
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == tgen_pkg::S_OUT) && out_free && active_ff) |=>
      (index_ff == LENGTH_BITS'($past(index_ff) + LENGTH_BITS'(1))))
      else $error("index did not advance");

   // A request is taken only when the previous result has been loaded.
   a_take_after_load: assert property (@(posedge clock) disable iff (reset)
      req_take |-> $past(state_ff) == tgen_pkg::S_OUT || $past(state_ff) == tgen_pkg::S_IDLE)
      else $error("request taken during a computation");

endmodule

`default_nettype wire

// ----- bench/tb_tone_generator_with_envelope_core.sv -----
// Self-checking testbench for the tone generator core, with its own sample predictor.
`timescale 1ns / 100ps

module tb_tone_generator_with_envelope_core;

   localparam int TBL_BITS = tgen_pkg::TABLE_ADDR_BITS_DEF;

   // Shape codes beyond the defined waveforms; the block plays silence for them.
   localparam logic [2:0] SHAPE_SILENT     = 3'd5;
   localparam logic [2:0] SHAPE_SILENT_TOP = 3'd7;
   localparam logic [2:0] SHAPE_CYCLE [5] = '{tgen_pkg::SHAPE_RAISED_COS,
                                             tgen_pkg::SHAPE_NOISY_SINE,
                                             tgen_pkg::SHAPE_NOISY_SQUARE,
                                             tgen_pkg::SHAPE_SQUARE,
                                             tgen_pkg::SHAPE_NOISE};

   typedef struct packed {
      logic [7:0] sample;
      logic       last_of_note;
      logic       playing;
   } tone_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic                             req_start_note = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [7:0]                       rsp_sample;
   logic                             rsp_last_of_note;
   logic                             rsp_playing;
   logic                             csr_wr_en = 1'b0;
   logic [tgen_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tgen_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Stimulus and expectation stores.
   logic            pending_starts [$];
   tone_result_type expected_samples [$];
   int              idle_pct = 0;
   int              stall_pct = 0;
   int              mismatches = 0;

   // Predicted voice: register copy and running state.
   tgen_pkg::cfg_type voice_cfg = '0;
   logic [31:0]       acc_phase = '0;
   logic [23:0]       note_pos = '0;
   logic [31:0]       env_q16 = '0;
   logic [31:0]       noise_reg = tgen_pkg::LFSR_SEED;
   logic              note_on = 1'b0;

   tone_generator_with_envelope_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_note   (req_start_note),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_last_of_note (rsp_last_of_note),
      .rsp_playing      (rsp_playing),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Polynomial sine over one quarter wave, Q16 in and out.
   function automatic logic [31:0] quarter_sine(input logic [16:0] x);
      logic [63:0] xw, x2, t;
      xw = x;
      x2 = (xw * xw) >> 16;
      t = tgen_pkg::SIN_C5 - ((x2 * tgen_pkg::SIN_C7) >> 16);
      t = tgen_pkg::SIN_C3 - ((x2 * t) >> 16);
      t = tgen_pkg::SIN_C1 - ((x2 * t) >> 16);
      t = (xw * t) >> 16;
      return (t > tgen_pkg::ONE_Q16) ? {15'd0, tgen_pkg::ONE_Q16} : t[31:0];
   endfunction

   // Sine lifted into 0..1, found by folding the quarter wave.
   function automatic logic [31:0] raised_q16(input logic [31:0] p);
      logic [16:0] x;
      logic [31:0] m;
      x = p[30] ? tgen_pkg::ONE_Q16 - {1'b0, p[29:14]} : {1'b0, p[29:14]};
      m = quarter_sine(x);
      return p[31] ? (tgen_pkg::ONE_Q16 - m) >> 1 : (tgen_pkg::ONE_Q16 + m) >> 1;
   endfunction

   function automatic logic sine_positive(input logic [31:0] p);
      return (p[31:30] == 2'd0 && p[29:14] != 16'd0) || p[31:30] == 2'd1;
   endfunction

   // One Galois shift; the noise value is the upper half afterwards.
   function automatic logic [31:0] next_noise();
      logic lsb;
      lsb = noise_reg[0];
      noise_reg = noise_reg >> 1;
      if (lsb) begin
         noise_reg = noise_reg ^ tgen_pkg::LFSR_TAPS;
      end
      return {16'd0, noise_reg[31:16]};
   endfunction

   function automatic logic [31:0] wave_q16();
      logic [31:0] p, n;
      logic [63:0] w;
      p = acc_phase & ~((32'd1 << (32 - TBL_BITS)) - 32'd1);
      case (voice_cfg.wave_shape)
         tgen_pkg::SHAPE_RAISED_COS: return raised_q16(p + tgen_pkg::QUARTER_TURN);
         tgen_pkg::SHAPE_NOISY_SINE: begin
            n = raised_q16(p);
            w = (64'(n) * next_noise()) >> 16;
            return w[31:0];
         end
         tgen_pkg::SHAPE_NOISY_SQUARE: begin
            n = next_noise();
            return sine_positive(p) ? n : 32'd0;
         end
         tgen_pkg::SHAPE_SQUARE:
            return sine_positive(p) ? {15'd0, tgen_pkg::ONE_Q16} : 32'd0;
         tgen_pkg::SHAPE_NOISE: return next_noise();
         default: return 32'd0;
      endcase
   endfunction

   // Advances the predicted voice by one sample tick and returns the expected result.
   function automatic tone_result_type tone_tick(input logic start);
      tone_result_type res;
      logic [63:0]     prod;
      logic [23:0]     j;
      logic            last;
      res = '0;
      if (start) begin
         note_pos = '0;
         env_q16 = (voice_cfg.attack_length == '0) ? {15'd0, tgen_pkg::ONE_Q16} : 32'd0;
         note_on = (voice_cfg.note_length != '0);
      end
      if (!note_on) begin
         return res;
      end
      j = note_pos;
      prod = (64'(env_q16) * voice_cfg.volume * wave_q16()) >> 32;
      res.sample = (prod > 64'd255) ? tgen_pkg::SAMPLE_MAX : prod[7:0];

      // Envelope rises during the attack, falls once past the fade start.
      if (j < voice_cfg.attack_length) begin
         env_q16 = env_q16 + voice_cfg.attack_step;
         if (env_q16 > tgen_pkg::ONE_Q16) begin
            env_q16 = {15'd0, tgen_pkg::ONE_Q16};
         end
      end else if (j > voice_cfg.fade_start) begin
         env_q16 = (env_q16 > voice_cfg.fade_step) ? env_q16 - voice_cfg.fade_step : 32'd0;
      end

      acc_phase = acc_phase + voice_cfg.phase_step;
      last = ({8'd0, j} == ({8'd0, voice_cfg.note_length} - 32'd1));
      note_pos = j + 24'd1;
      if (last) begin
         note_on = 1'b0;
      end
      res.last_of_note = last;
      res.playing = 1'b1;
      return res;
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
      mismatches++;
      $display("ERROR %0t: %s expected %0d got %0d", $realtime, what, want, got);
   endtask

   // Driver: presents queued requests, holding each one while it is stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_start_note <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_samples.push_back(tone_tick(req_start_note));
         end
         if (!req_valid || !req_stall) begin
            if (pending_starts.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_start_note <= pending_starts.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result against the oldest expectation.
   always @(posedge clock) begin
      tone_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               flag_mismatch("unexpected result, sample", 0, rsp_sample);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample !== want.sample) begin
                  flag_mismatch("sample", want.sample, rsp_sample);
               end
               if (rsp_last_of_note !== want.last_of_note) begin
                  flag_mismatch("last_of_note", want.last_of_note, rsp_last_of_note);
               end
               if (rsp_playing !== want.playing) begin
                  flag_mismatch("playing", want.playing, rsp_playing);
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic wait_drained();
      while (pending_starts.size() != 0 || req_valid || expected_samples.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [tgen_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [tgen_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         tgen_pkg::REG_PHASE_STEP:    voice_cfg.phase_step = data;
         tgen_pkg::REG_VOLUME:        voice_cfg.volume = data[7:0];
         tgen_pkg::REG_NOTE_LENGTH:   voice_cfg.note_length = data[23:0];
         tgen_pkg::REG_ATTACK_LENGTH: voice_cfg.attack_length = data[23:0];
         tgen_pkg::REG_FADE_START:    voice_cfg.fade_start = data[23:0];
         tgen_pkg::REG_WAVE_SHAPE:    voice_cfg.wave_shape = data[2:0];
         tgen_pkg::REG_ATTACK_STEP:   voice_cfg.attack_step = data[16:0];
         tgen_pkg::REG_FADE_STEP:     voice_cfg.fade_step = data[16:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Writes all eight registers back to back; only called with the block idle.
   task automatic set_voice(input tgen_pkg::cfg_type c);
      write_reg(tgen_pkg::REG_PHASE_STEP, c.phase_step);
      write_reg(tgen_pkg::REG_VOLUME, c.volume);
      write_reg(tgen_pkg::REG_NOTE_LENGTH, c.note_length);
      write_reg(tgen_pkg::REG_ATTACK_LENGTH, c.attack_length);
      write_reg(tgen_pkg::REG_FADE_START, c.fade_start);
      write_reg(tgen_pkg::REG_WAVE_SHAPE, c.wave_shape);
      write_reg(tgen_pkg::REG_ATTACK_STEP, c.attack_step);
      write_reg(tgen_pkg::REG_FADE_STEP, c.fade_step);
      csr_wr_en <= 1'b0;
   endtask

   // Queues the low n bits of a pattern, oldest request in the top bit.
   task automatic queue_pattern(input int n, input logic [31:0] bits);
      for (int i = n - 1; i >= 0; i--) begin
         pending_starts.push_back(bits[i]);
      end
   endtask

   // Mostly whole notes, some cut short by a restart, plus stray requests.
   task automatic queue_notes(input int n);
      int made, len, r, extra;
      made = 0;
      while (made < n) begin
         r = $urandom_range(0, 99);
         if (r < 82) begin
            len = voice_cfg.note_length;
            if (len > 40) begin
               len = 40;
            end
            if (len == 0) begin
               len = 2;
            end
            if (r < 12) begin
               len = $urandom_range(1, len);
            end
            pending_starts.push_back(1'b1);
            for (int i = 1; i < len; i++) begin
               pending_starts.push_back(1'b0);
            end
            extra = $urandom_range(0, 2);
            for (int i = 0; i < extra; i++) begin
               pending_starts.push_back(1'b0);
            end
            made += len + extra;
         end else begin
            extra = $urandom_range(1, 4);
            for (int i = 0; i < extra; i++) begin
               pending_starts.push_back(1'($urandom_range(0, 1)));
            end
            made += extra;
         end
      end
   endtask

   function automatic tgen_pkg::cfg_type random_voice(input int k);
      tgen_pkg::cfg_type c;
      c.phase_step = $urandom();
      c.volume = (k == 3) ? 8'd255 : 8'($urandom_range(0, 255));
      if (k == 9) begin
         c.note_length = 24'd1;
      end else if (k == 7) begin
         c.note_length = 24'($urandom_range(100, 300));
      end else begin
         c.note_length = 24'($urandom_range(1, 24));
      end
      c.attack_length = (k == 6) ? 24'd0 : 24'($urandom_range(0, c.note_length + 2));
      c.fade_start = 24'($urandom_range(0, c.note_length + 2));
      c.wave_shape = (k == 8) ? SHAPE_SILENT_TOP : SHAPE_CYCLE[k % 5];
      c.attack_step = 17'($urandom_range(0, 65536));
      c.fade_step = 17'($urandom_range(0, 65536));
      return c;
   endfunction

   // Main sequence: reset, directed notes, then randomized phases.
   initial begin
      tgen_pkg::cfg_type c;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Idle tick, a full note with saturating attack and fade to zero, a restart.
      c = '{phase_step: 32'h0400_0000, volume: 8'd255, note_length: 24'd6,
            attack_length: 24'd2, fade_start: 24'd2,
            wave_shape: tgen_pkg::SHAPE_RAISED_COS,
            attack_step: 17'd65536, fade_step: 17'd30000};
      set_voice(c);
      queue_pattern(13, 32'b0_100000_0_10010);
      wait_drained();

      // Zero note length: a start plays nothing.
      c = '0;
      c.wave_shape = tgen_pkg::SHAPE_SQUARE;
      set_voice(c);
      queue_pattern(2, 32'b10);
      wait_drained();

      // Undefined shape gives silence; zero attack starts at full level.
      c = '{phase_step: 32'h1234_5678, volume: 8'd200, note_length: 24'd3,
            attack_length: 24'd0, fade_start: 24'd0, wave_shape: SHAPE_SILENT,
            attack_step: 17'd1000, fade_step: 17'd1000};
      set_voice(c);
      queue_pattern(3, 32'b100);
      wait_drained();

      // Phase step, volume and lengths at their top values, both steps at full level, noise shape.
      c = '{phase_step: 32'hFFFF_FFFF, volume: 8'd255, note_length: 24'hFF_FFFF,
            attack_length: 24'hFF_FFFF, fade_start: 24'hFF_FFFF,
            wave_shape: tgen_pkg::SHAPE_NOISE,
            attack_step: 17'd65536, fade_step: 17'd65536};
      set_voice(c);
      queue_pattern(4, 32'b1000);
      wait_drained();

      // Random phases; each drains once in the middle before its second half.
      for (int k = 0; k < 10; k++) begin
         set_voice(random_voice(k));
         idle_pct = (k % 4 == 1 || k % 4 == 3) ? ((k % 4 == 1) ? 47 : 35) : 0;
         stall_pct = (k % 4 == 2 || k % 4 == 3) ? ((k % 4 == 2) ? 47 : 35) : 0;
         queue_notes(24);
         wait_drained();
         queue_notes(25);
         wait_drained();
      end

      idle_pct = 0;
      stall_pct = 0;
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("tone_generator_with_envelope_core: match");
      end else begin
         $display("tone_generator_with_envelope_core: mismatch");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("tone_generator_with_envelope_core: mismatch");
      $finish;
   end

endmodule
